// ===== rtl/mscp_pkg.sv =====
`timescale 1ns / 1ps
package mscp_pkg;

	localparam int CB     = 8;
	localparam int VB     = 32;
	localparam int DW     = VB + CB;
	localparam int NE     = 4;
	localparam int MAXPIX = 6;

	// corner order in the sign index
	localparam int C_TL = 0;
	localparam int C_TR = 1;
	localparam int C_BL = 2;
	localparam int C_BR = 3;

	// edge order
	localparam int E_TOP    = 0;
	localparam int E_LEFT   = 1;
	localparam int E_RIGHT  = 2;
	localparam int E_BOTTOM = 3;

	localparam logic [3:0] IDX_NONE    = 4'b0000;
	localparam logic [3:0] IDX_ALL     = 4'b1111;
	localparam logic [3:0] IDX_SADDLE6 = 4'b0110;
	localparam logic [3:0] IDX_SADDLE9 = 4'b1001;

	localparam logic [3:0] EP_TL = 4'b0011;
	localparam logic [3:0] EP_TR = 4'b0101;
	localparam logic [3:0] EP_LB = 4'b1010;
	localparam logic [3:0] EP_RB = 4'b1100;
	localparam logic [3:0] EP_TB = 4'b1001;
	localparam logic [3:0] EP_LR = 4'b0110;

	typedef struct packed {
		logic [CB-1:0]        left_x;
		logic [CB-1:0]        top_y;
		logic [CB-1:0]        right_x;
		logic [CB-1:0]        bottom_y;
		logic signed [VB-1:0] value_top_left;
		logic signed [VB-1:0] value_top_right;
		logic signed [VB-1:0] value_bottom_left;
		logic signed [VB-1:0] value_bottom_right;
	} cell_t;

	typedef struct packed {
		logic [CB-1:0] pixel_x;
		logic [CB-1:0] pixel_y;
		logic          last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
	} point_t;

	typedef struct packed {
		logic [CB-1:0] x1;
		logic [CB-1:0] y1;
		logic [CB-1:0] x2;
		logic [CB-1:0] y2;
		logic [3:0]    idx;
		logic          top_left;
	} ctx_t;

	typedef struct packed {
		logic          diff;
		logic          dpos;
		logic [CB-1:0] p;
		logic [CB-1:0] q;
		logic [CB-1:0] mid;
	} einfo_t;

	typedef struct packed {
		logic [VB-1:0] ma;
		logic [CB-1:0] ad;
		logic [VB:0]   den;
		einfo_t        info;
	} edge_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [VB:0]   den;
		logic [CB-1:0] quo;
		einfo_t        info;
	} div_t;

	function automatic logic [3:0] edge_pairs(input logic [3:0] idx);
		logic [3:0] e;
		case (idx)
			4'd1, 4'd14: e = EP_TL;
			4'd2, 4'd13: e = EP_TR;
			4'd3, 4'd12: e = EP_LR;
			4'd4, 4'd11: e = EP_LB;
			4'd5, 4'd10: e = EP_TB;
			4'd7, 4'd8:  e = EP_RB;
			default:     e = 4'b0000;
		endcase
		return e;
	endfunction

endpackage

// ===== rtl/marching_squares_cell_pixels.sv =====
`timescale 1ns / 1ps
// marching squares cell rasteriser
// cell channel (cell_valid, cell_stall, cell_data): one beat per grid cell, with
// its edge coordinates and four signed Q16.16 corner values.
// pixel channel (pixel_valid, pixel_stall, pixel): zero to six beats per
// cell, in cell order; last_pixel marks the final beat of a cell, a uniform
// cell gives no beat at all.
// the crossing divide is a restoring divider with one quotient bit per
// pipeline stage. throughput: one cell per cycle through the pipe while
// it advances; the output list register drains one pixel a cycle while
// the receiver does not stall, and a cell with pixels holds the pipe
// until its last pixel is sent.
// the whole pipe advances together when the output list is empty or sends
// its last pixel; while the receiver stalls, pixel and cell_stall hold.
// reset clears every valid bit and the output list count and pointer; no clearing pass.
module marching_squares_cell_pixels (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cell_valid,
	output logic            cell_stall,
	input  mscp_pkg::cell_t cell_data,
	output logic            pixel_valid,
	input  logic            pixel_stall,
	output mscp_pkg::pixel_t pixel
);
	import mscp_pkg::*;

	logic adv;

	// stage 1: input register
	cell_t cell_s1;
	logic  vld_s1;

	// stage 2: signs, magnitudes, edge set-up
	edge_t [NE-1:0] edge_c, edge_s2;
	ctx_t           ctx_c, ctx_s2;
	logic           vld_s2;

	logic [VB-1:0] val [NE];
	logic [VB-1:0] mag [NE];
	logic [VB-1:0] maf [NE];
	logic [3:0]    pos;
	logic [VB:0]   diag_main, diag_anti;

	always_comb begin
		val[C_TL] = cell_s1.value_top_left;
		val[C_TR] = cell_s1.value_top_right;
		val[C_BL] = cell_s1.value_bottom_left;
		val[C_BR] = cell_s1.value_bottom_right;
		for (int k = 0; k < NE; k++) begin
			mag[k] = val[k][VB-1] ? (~val[k] + 1'b1) : val[k];
			pos[k] = !val[k][VB-1] && (val[k] != '0);
			maf[k] = (mag[k] == '0) ? VB'(1) : mag[k];
		end
	end

	function automatic edge_t edge_set(input logic [CB-1:0] p, input logic [CB-1:0] q,
			input logic pa, input logic pb, input logic [VB-1:0] ma,
			input logic [VB-1:0] mb);
		edge_t e;
		logic [CB:0] sum;
		sum         = {1'b0, p} + {1'b0, q};
		e.ma        = ma;
		e.den       = {1'b0, ma} + {1'b0, mb};
		e.info.diff = pa ^ pb;
		e.info.dpos = q > p;
		e.ad        = (q > p) ? (q - p) : (p - q);
		e.info.p    = p;
		e.info.q    = q;
		e.info.mid  = sum[CB:1];
		return e;
	endfunction

	always_comb begin
		edge_c[E_TOP]    = edge_set(cell_s1.left_x, cell_s1.right_x, pos[C_TL], pos[C_TR],
			maf[C_TL], maf[C_TR]);
		edge_c[E_BOTTOM] = edge_set(cell_s1.left_x, cell_s1.right_x, pos[C_BL], pos[C_BR],
			maf[C_BL], maf[C_BR]);
		edge_c[E_LEFT]   = edge_set(cell_s1.top_y, cell_s1.bottom_y, pos[C_TL], pos[C_BL],
			maf[C_TL], maf[C_BL]);
		edge_c[E_RIGHT]  = edge_set(cell_s1.top_y, cell_s1.bottom_y, pos[C_TR], pos[C_BR],
			maf[C_TR], maf[C_BR]);
		diag_main   = {1'b0, mag[C_TL]} + {1'b0, mag[C_BR]};
		diag_anti   = {1'b0, mag[C_TR]} + {1'b0, mag[C_BL]};
		ctx_c.x1    = cell_s1.left_x;
		ctx_c.y1    = cell_s1.top_y;
		ctx_c.x2    = cell_s1.right_x;
		ctx_c.y2    = cell_s1.bottom_y;
		ctx_c.idx   = pos;
		ctx_c.top_left = (pos == IDX_SADDLE6) ? (diag_main < diag_anti)
			: (diag_main <= diag_anti);
	end

	// divider: entry 0 holds the product, each later entry one quotient bit
	div_t [NE-1:0] div_s  [CB+1];
	ctx_t          dctx_s [CB+1];
	logic          dvld_s [CB+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_s1 <= cell_data;
			edge_s2 <= edge_c;
			ctx_s2  <= ctx_c;
			for (int k = 0; k < NE; k++) begin
				div_s[0][k].rem  <= edge_s2[k].ma * edge_s2[k].ad;
				div_s[0][k].den  <= edge_s2[k].den;
				div_s[0][k].quo  <= '0;
				div_s[0][k].info <= edge_s2[k].info;
			end
			dctx_s[0] <= ctx_s2;
		end
	end

	for (genvar j = 0; j < CB; j++) begin : g_div
		localparam int BIT = CB - 1 - j;
		div_t [NE-1:0] nxt;
		logic [DW-1:0] sh [NE];
		always_comb begin
			for (int k = 0; k < NE; k++) begin
				nxt[k] = div_s[j][k];
				sh[k]  = DW'(div_s[j][k].den) << BIT;
				if (div_s[j][k].rem >= sh[k]) begin
					nxt[k].rem      = div_s[j][k].rem - sh[k];
					nxt[k].quo[BIT] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[j+1]  <= nxt;
				dctx_s[j+1] <= dctx_s[j];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[j+1] <= 1'b0;
			end else if (adv) begin
				dvld_s[j+1] <= dvld_s[j];
			end
		end
	end

	// stage 3: rounding and clamp
	logic [CB-1:0] cross_c [NE];
	logic [CB-1:0] cross_s3 [NE];
	ctx_t          ctx_s3;
	logic          vld_s3;

	always_comb begin
		for (int k = 0; k < NE; k++) begin
			logic [VB+1:0] r2;
			logic [CB:0]   qr;
			logic [CB:0]   sum;
			r2  = {div_s[CB][k].rem[VB:0], 1'b0};
			qr  = {1'b0, div_s[CB][k].quo} + (CB+1)'(r2 >= {1'b0, div_s[CB][k].den});
			sum = {1'b0, div_s[CB][k].info.p} + qr;
			if (!div_s[CB][k].info.diff) begin
				cross_c[k] = div_s[CB][k].info.mid;
			end else if (div_s[CB][k].info.dpos) begin
				cross_c[k] = sum[CB-1:0];
			end else begin
				cross_c[k] = (qr == '0) ? div_s[CB][k].info.q : div_s[CB][k].info.p;
			end
		end
	end

	// stage 4: pixel list
	point_t     list_c [MAXPIX];
	logic [2:0] cnt_c;
	point_t     list_s4 [MAXPIX];
	logic [2:0] cnt_s4;
	logic       vld_s4;

	function automatic logic far_apart(input point_t a, input point_t b);
		logic signed [CB:0] dx, dy;
		dx = $signed({1'b0, a.x}) - $signed({1'b0, b.x});
		dy = $signed({1'b0, a.y}) - $signed({1'b0, b.y});
		return (dx > 1) || (dx < -1) || (dy > 1) || (dy < -1);
	endfunction

	function automatic point_t mid_point(input point_t a, input point_t b);
		point_t m;
		logic [CB:0] sx, sy;
		sx  = {1'b0, a.x} + {1'b0, b.x};
		sy  = {1'b0, a.y} + {1'b0, b.y};
		m.x = sx[CB:1];
		m.y = sy[CB:1];
		return m;
	endfunction

	always_comb begin
		point_t pt, pl, pr, pb, a, b, c, d, m1, m2;
		logic [3:0] e;
		logic saddle, f1, f2;
		pt = '{x: cross_s3[E_TOP],    y: ctx_s3.y1};
		pl = '{x: ctx_s3.x1,          y: cross_s3[E_LEFT]};
		pr = '{x: ctx_s3.x2,          y: cross_s3[E_RIGHT]};
		pb = '{x: cross_s3[E_BOTTOM], y: ctx_s3.y2};
		e  = edge_pairs(ctx_s3.idx);
		saddle = (ctx_s3.idx == IDX_SADDLE6) || (ctx_s3.idx == IDX_SADDLE9);
		if (saddle) begin
			a = pt;
			b = ctx_s3.top_left ? pl : pr;
			c = ctx_s3.top_left ? pr : pl;
			d = pb;
		end else begin
			a = e[E_TOP] ? pt : (e[E_LEFT] ? pl : pr);
			b = e[E_BOTTOM] ? pb : (e[E_RIGHT] ? pr : pl);
			c = pr;
			d = pb;
		end
		f1 = far_apart(a, b);
		f2 = far_apart(c, d);
		m1 = mid_point(a, b);
		m2 = mid_point(c, d);
		list_c[0] = a;
		list_c[1] = b;
		list_c[2] = f1 ? m1 : c;
		list_c[3] = f1 ? c : d;
		list_c[4] = f1 ? d : m2;
		list_c[5] = m2;
		if ((ctx_s3.idx == IDX_NONE) || (ctx_s3.idx == IDX_ALL)) begin
			cnt_c = 3'd0;
		end else if (saddle) begin
			cnt_c = 3'd4 + {2'b00, f1} + {2'b00, f2};
		end else begin
			cnt_c = 3'd2 + {2'b00, f1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cross_s3 <= cross_c;
			ctx_s3   <= dctx_s[CB];
			list_s4  <= list_c;
			cnt_s4   <= cnt_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			dvld_s[0] <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
		end else if (adv) begin
			vld_s1    <= cell_valid;
			vld_s2    <= vld_s1;
			dvld_s[0] <= vld_s2;
			vld_s3    <= dvld_s[CB];
			vld_s4    <= vld_s3;
		end
	end

	// output list
	point_t     list_q [MAXPIX];
	logic [2:0] cnt_q, ptr_q;
	logic       last;

	assign pixel_valid = ptr_q < cnt_q;
	assign last        = ptr_q == (cnt_q - 3'd1);
	assign adv         = !pixel_valid || (!pixel_stall && last);
	assign cell_stall  = !adv;

	always_ff @(posedge clk) begin
		if (adv) begin
			list_q <= list_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (adv) begin
			cnt_q <= vld_s4 ? cnt_s4 : 3'd0;
			ptr_q <= '0;
		end else if (pixel_valid && !pixel_stall) begin
			ptr_q <= ptr_q + 3'd1;
		end
	end

	always_comb begin
		pixel.pixel_x    = list_q[ptr_q].x;
		pixel.pixel_y    = list_q[ptr_q].y;
		pixel.last_pixel = last;
	end

endmodule

// ===== rtl/mscp_checker.sv =====
`timescale 1ns / 1ps
module mscp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             cell_valid,
	input logic             cell_stall,
	input mscp_pkg::cell_t  cell_data,
	input logic             pixel_valid,
	input logic             pixel_stall,
	input mscp_pkg::pixel_t pixel
);
	import mscp_pkg::*;

	// a stalled pixel beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
		else $error("stalled pixel beat changed");

	// the cell side only stalls behind a pending pixel
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cell_stall |-> pixel_valid)
		else $error("cell stall with no pixel pending");

	// a cell's pixel run does not break off before its last beat
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall && !pixel.last_pixel |=> pixel_valid)
		else $error("pixel run ended without last_pixel");

	// no new cell while a cell still has pixels to send
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel.last_pixel |-> cell_stall)
		else $error("cell taken mid run");

endmodule

bind marching_squares_cell_pixels mscp_checker u_mscp_checker (.*);
